### design/cpcr_pkg.sv
// shared types, constants and helpers for the circle pair collision response unit
package cpcr_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int CW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

    localparam int ADDR_W = 3;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DAMPING = '0;
    localparam logic [16:0] DAMPING_RST = 17'd49152;

    localparam int SQRT_BITS = 32;
    localparam int SQ_PER = 2;
    localparam int SHARE_BITS = 17;
    localparam int UNIT_BITS = 25;
    localparam int DIV_PER = 2;

    localparam int FRONT_STAGES = 3;
    localparam int ROOT_STAGES = SQRT_BITS / SQ_PER;
    localparam int UNIT_STAGES = 1 + (UNIT_BITS + DIV_PER - 1) / DIV_PER;
    localparam int OUT_STAGES = 2;

    typedef struct packed {
        logic [15:0]        first_id;
        logic [15:0]        second_id;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic [30:0]        first_radius;
        logic [30:0]        second_radius;
        logic [16:0]        first_bounce;
        logic [16:0]        second_bounce;
        logic [31:0]        first_mass;
        logic [31:0]        second_mass;
    } t_in;

    typedef struct packed {
        logic [15:0]        out_first_id;
        logic [15:0]        out_second_id;
        logic signed [31:0] first_move_x;
        logic signed [31:0] first_move_y;
        logic signed [31:0] second_move_x;
        logic signed [31:0] second_move_y;
        logic               overlap;
        logic               degenerate;
    } t_out;

    // front end to square root and share dividers
    typedef struct packed {
        logic [15:0] first_id;
        logic [15:0] second_id;
        logic        neg_x;
        logic        neg_y;
        logic        pos_x;
        logic        pos_y;
        logic [31:0] adx;
        logic [31:0] ady;
        logic [63:0] rem;
        logic [31:0] root;
        logic [31:0] rsum;
        logic [18:0] bm;
        logic [32:0] msum;
        logic        mzero;
        logic [48:0] rem1;
        logic [48:0] rem2;
        logic [16:0] q1;
        logic [16:0] q2;
        logic        ovl;
        logic        dgn;
    } t_geo;

    // direction dividers and push scaling
    typedef struct packed {
        logic [15:0] first_id;
        logic [15:0] second_id;
        logic        neg_x;
        logic        neg_y;
        logic        pos_x;
        logic        pos_y;
        logic        ovl;
        logic        dgn;
        logic        mzero;
        logic [16:0] q1;
        logic [16:0] q2;
        logic [31:0] dlen;
        logic [56:0] remx;
        logic [56:0] remy;
        logic [24:0] ux;
        logic [24:0] uy;
        logic [31:0] pen;
        logic [18:0] bm;
        logic [32:0] p1;
        logic [34:0] p2;
        logic [34:0] mag1;
        logic [34:0] mag2;
    } t_dir;

    // unit vector and magnitudes into the output stages
    typedef struct packed {
        logic [15:0] first_id;
        logic [15:0] second_id;
        logic        neg_x;
        logic        neg_y;
        logic        pos_x;
        logic        pos_y;
        logic        ovl;
        logic        dgn;
        logic [24:0] ux;
        logic [24:0] uy;
        logic [34:0] mag1;
        logic [34:0] mag2;
    } t_mag;

    function automatic logic signed [32:0] sext_coord(input logic [31:0] v);
        logic [32:0] r;
        for (int i = 0; i < 33; i++) begin
            r[i] = v[(i < CW) ? i : CW - 1];
        end
        return signed'(r);
    endfunction

    function automatic logic [31:0] sat_move(input logic neg, input logic [36:0] mag);
        logic [36:0] lim;
        logic [36:0] m;
        logic [36:0] nm;
        lim = neg ? (37'd1 << (CW - 1)) : ((37'd1 << (CW - 1)) - 37'd1);
        m   = (mag > lim) ? lim : mag;
        nm  = ~m + 37'd1;
        return neg ? nm[31:0] : m[31:0];
    endfunction

endpackage

### design/cpcr_front.sv
// front end: differences, squares, overlap test and first share quotient bit
module cpcr_front import cpcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_item,
    output logic o_valid,
    input  logic i_ready,
    output t_geo o_item
);

    typedef struct packed {
        logic [15:0] first_id;
        logic [15:0] second_id;
        logic        neg_x;
        logic        neg_y;
        logic        pos_x;
        logic        pos_y;
        logic [31:0] adx;
        logic [31:0] ady;
        logic [31:0] rsum;
        logic [32:0] msum;
        logic [18:0] bm;
        logic [31:0] m1;
        logic [31:0] m2;
    } t_f1;

    typedef struct packed {
        logic [15:0] first_id;
        logic [15:0] second_id;
        logic        neg_x;
        logic        neg_y;
        logic        pos_x;
        logic        pos_y;
        logic [31:0] adx;
        logic [31:0] ady;
        logic [31:0] rsum;
        logic [32:0] msum;
        logic [18:0] bm;
        logic [63:0] sqx;
        logic [63:0] sqy;
        logic [63:0] rsq;
        logic [48:0] n1;
        logic [48:0] n2;
    } t_f2;

    t_f1  r_f1, n_f1;
    t_f2  r_f2, n_f2;
    t_geo r_f3, n_f3;

    logic [FRONT_STAGES-1:0] r_vld;
    logic [FRONT_STAGES:0]   w_rdy;
    logic [FRONT_STAGES-1:0] w_vin;

    assign w_rdy[FRONT_STAGES] = i_ready;
    assign w_vin = {r_vld[FRONT_STAGES-2:0], i_valid};

    for (genvar k = 0; k < FRONT_STAGES; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    always_comb begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        dx = sext_coord(i_item.first_x) - sext_coord(i_item.second_x);
        dy = sext_coord(i_item.first_y) - sext_coord(i_item.second_y);
        n_f1.first_id  = i_item.first_id;
        n_f1.second_id = i_item.second_id;
        n_f1.neg_x     = dx[32];
        n_f1.neg_y     = dy[32];
        n_f1.pos_x     = !dx[32] && (dx != '0);
        n_f1.pos_y     = !dy[32] && (dy != '0);
        n_f1.adx       = dx[32] ? 32'(-dx) : dx[31:0];
        n_f1.ady       = dy[32] ? 32'(-dy) : dy[31:0];
        n_f1.rsum      = {1'b0, i_item.first_radius} + {1'b0, i_item.second_radius};
        n_f1.msum      = {1'b0, i_item.first_mass} + {1'b0, i_item.second_mass};
        n_f1.bm        = 19'(i_item.first_bounce) + 19'(i_item.second_bounce) + 19'd131072;
        n_f1.m1        = i_item.first_mass;
        n_f1.m2        = i_item.second_mass;
    end

    always_comb begin
        n_f2.first_id  = r_f1.first_id;
        n_f2.second_id = r_f1.second_id;
        n_f2.neg_x     = r_f1.neg_x;
        n_f2.neg_y     = r_f1.neg_y;
        n_f2.pos_x     = r_f1.pos_x;
        n_f2.pos_y     = r_f1.pos_y;
        n_f2.adx       = r_f1.adx;
        n_f2.ady       = r_f1.ady;
        n_f2.rsum      = r_f1.rsum;
        n_f2.msum      = r_f1.msum;
        n_f2.bm        = r_f1.bm;
        n_f2.sqx       = 64'(r_f1.adx) * 64'(r_f1.adx);
        n_f2.sqy       = 64'(r_f1.ady) * 64'(r_f1.ady);
        n_f2.rsq       = 64'(r_f1.rsum) * 64'(r_f1.rsum);
        n_f2.n1        = {1'b0, r_f1.m1, 16'b0} + 49'(r_f1.msum >> 1);
        n_f2.n2        = {1'b0, r_f1.m2, 16'b0} + 49'(r_f1.msum >> 1);
    end

    always_comb begin
        logic [64:0] sum;
        logic [48:0] dsh;
        sum = {1'b0, r_f2.sqx} + {1'b0, r_f2.sqy};
        dsh = {r_f2.msum, 16'b0};
        n_f3.first_id  = r_f2.first_id;
        n_f3.second_id = r_f2.second_id;
        n_f3.neg_x     = r_f2.neg_x;
        n_f3.neg_y     = r_f2.neg_y;
        n_f3.pos_x     = r_f2.pos_x;
        n_f3.pos_y     = r_f2.pos_y;
        n_f3.adx       = r_f2.adx;
        n_f3.ady       = r_f2.ady;
        n_f3.rem       = sum[63:0];
        n_f3.root      = '0;
        n_f3.rsum      = r_f2.rsum;
        n_f3.bm        = r_f2.bm;
        n_f3.msum      = r_f2.msum;
        n_f3.mzero     = (r_f2.msum == '0);
        n_f3.q1        = '0;
        n_f3.q2        = '0;
        n_f3.q1[16]    = (r_f2.n1 >= dsh);
        n_f3.q2[16]    = (r_f2.n2 >= dsh);
        n_f3.rem1      = n_f3.q1[16] ? (r_f2.n1 - dsh) : r_f2.n1;
        n_f3.rem2      = n_f3.q2[16] ? (r_f2.n2 - dsh) : r_f2.n2;
        n_f3.ovl       = !sum[64] && (sum[63:0] < r_f2.rsq);
        n_f3.dgn       = (r_f2.adx == '0) && (r_f2.ady == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < FRONT_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_f1 <= n_f1;
        end
        if (w_rdy[1]) begin
            r_f2 <= n_f2;
        end
        if (w_rdy[2]) begin
            r_f3 <= n_f3;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[FRONT_STAGES-1];
    assign o_item  = r_f3;

endmodule

### design/cpcr_root.sv
// pipelined square root of the squared distance, with the mass share dividers alongside
module cpcr_root import cpcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_geo i_item,
    output logic o_valid,
    input  logic i_ready,
    output t_geo o_item
);

    t_geo r_st  [ROOT_STAGES];
    t_geo n_st  [ROOT_STAGES];
    t_geo w_src [ROOT_STAGES];

    logic [ROOT_STAGES-1:0] r_vld;
    logic [ROOT_STAGES:0]   w_rdy;
    logic [ROOT_STAGES-1:0] w_vin;

    assign w_rdy[ROOT_STAGES] = i_ready;
    assign w_vin = {r_vld[ROOT_STAGES-2:0], i_valid};

    for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
        localparam int SB = SHARE_BITS - 2 - k;

        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];

        if (k == 0) begin : g_first
            assign w_src[k] = i_item;
        end else begin : g_next
            assign w_src[k] = r_st[k-1];
        end

        always_comb begin
            t_geo        a;
            logic [65:0] t;
            logic [48:0] d;
            int          b;
            a = w_src[k];
            for (int j = 0; j < SQ_PER; j++) begin
                b = SQRT_BITS - 1 - SQ_PER * k - j;
                t = (66'(a.root) << (b + 1)) + (66'd1 << (2 * b));
                if ({2'b0, a.rem} >= t) begin
                    a.rem     = a.rem - t[63:0];
                    a.root[b] = 1'b1;
                end
            end
            d = 49'(a.msum) << SB;
            if (a.rem1 >= d) begin
                a.rem1     = a.rem1 - d;
                a.q1[SB]   = 1'b1;
            end
            if (a.rem2 >= d) begin
                a.rem2     = a.rem2 - d;
                a.q2[SB]   = 1'b1;
            end
            n_st[k] = a;
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < ROOT_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[ROOT_STAGES-1];
    assign o_item  = r_st[ROOT_STAGES-1];

endmodule

### design/cpcr_unit.sv
// direction dividers and push scaling by penetration, damping, restitution and mass share
module cpcr_unit import cpcr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [16:0] i_damping,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_geo        i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_mag        o_item
);

    localparam int P1_STAGE  = 1;
    localparam int P2_STAGE  = 2;
    localparam int MAG_STAGE = 3;

    t_dir r_st [UNIT_STAGES];
    t_dir n_st [UNIT_STAGES];

    logic [UNIT_STAGES-1:0] r_vld;
    logic [UNIT_STAGES:0]   w_rdy;
    logic [UNIT_STAGES-1:0] w_vin;

    assign w_rdy[UNIT_STAGES] = i_ready;
    assign w_vin = {r_vld[UNIT_STAGES-2:0], i_valid};

    for (genvar k = 0; k < UNIT_STAGES; k++) begin : g_stage
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];

        if (k == 0) begin : g_first
            always_comb begin
                n_st[k]           = '0;
                n_st[k].first_id  = i_item.first_id;
                n_st[k].second_id = i_item.second_id;
                n_st[k].neg_x     = i_item.neg_x;
                n_st[k].neg_y     = i_item.neg_y;
                n_st[k].pos_x     = i_item.pos_x;
                n_st[k].pos_y     = i_item.pos_y;
                n_st[k].ovl       = i_item.ovl;
                n_st[k].dgn       = i_item.dgn;
                n_st[k].mzero     = i_item.mzero;
                n_st[k].q1        = i_item.q1;
                n_st[k].q2        = i_item.q2;
                n_st[k].dlen      = i_item.root;
                n_st[k].remx      = {1'b0, i_item.adx, 24'b0} + 57'(i_item.root >> 1);
                n_st[k].remy      = {1'b0, i_item.ady, 24'b0} + 57'(i_item.root >> 1);
                n_st[k].pen       = i_item.rsum - i_item.root;
                n_st[k].bm        = i_item.bm;
            end
        end else begin : g_next
            always_comb begin
                t_dir        a;
                logic [56:0] d;
                logic [48:0] pr1;
                logic [51:0] pr2;
                logic [51:0] prm1;
                logic [51:0] prm2;
                logic [16:0] s1;
                logic [16:0] s2;
                int          b;
                a = r_st[k-1];
                for (int j = 0; j < DIV_PER; j++) begin
                    b = UNIT_BITS - 1 - DIV_PER * (k - 1) - j;
                    if (b >= 0) begin
                        d = 57'(a.dlen) << b;
                        if (a.remx >= d) begin
                            a.remx  = a.remx - d;
                            a.ux[b] = 1'b1;
                        end
                        if (a.remy >= d) begin
                            a.remy  = a.remy - d;
                            a.uy[b] = 1'b1;
                        end
                    end
                end
                pr1  = 49'(a.pen) * 49'(i_damping) + 49'd32768;
                pr2  = 52'(a.p1) * 52'(a.bm) + 52'd65536;
                s1   = a.mzero ? 17'd32768 : a.q1;
                s2   = a.mzero ? 17'd32768 : a.q2;
                prm1 = 52'(a.p2) * 52'(s2) + 52'd32768;
                prm2 = 52'(a.p2) * 52'(s1) + 52'd32768;
                if (k == P1_STAGE) begin
                    a.p1 = pr1[48:16];
                end
                if (k == P2_STAGE) begin
                    a.p2 = pr2[51:17];
                end
                if (k == MAG_STAGE) begin
                    a.mag1 = prm1[50:16];
                    a.mag2 = prm2[50:16];
                end
                n_st[k] = a;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < UNIT_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    always_comb begin
        o_item.first_id  = r_st[UNIT_STAGES-1].first_id;
        o_item.second_id = r_st[UNIT_STAGES-1].second_id;
        o_item.neg_x     = r_st[UNIT_STAGES-1].neg_x;
        o_item.neg_y     = r_st[UNIT_STAGES-1].neg_y;
        o_item.pos_x     = r_st[UNIT_STAGES-1].pos_x;
        o_item.pos_y     = r_st[UNIT_STAGES-1].pos_y;
        o_item.ovl       = r_st[UNIT_STAGES-1].ovl;
        o_item.dgn       = r_st[UNIT_STAGES-1].dgn;
        o_item.ux        = r_st[UNIT_STAGES-1].ux;
        o_item.uy        = r_st[UNIT_STAGES-1].uy;
        o_item.mag1      = r_st[UNIT_STAGES-1].mag1;
        o_item.mag2      = r_st[UNIT_STAGES-1].mag2;
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[UNIT_STAGES-1];

endmodule

### design/cpcr_out.sv
// per-axis move products, rounding, saturation and the output register
module cpcr_out import cpcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_mag i_item,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_item
);

    typedef struct packed {
        logic [15:0] first_id;
        logic [15:0] second_id;
        logic        neg_x;
        logic        neg_y;
        logic        pos_x;
        logic        pos_y;
        logic        ovl;
        logic        dgn;
        logic [59:0] px1;
        logic [59:0] py1;
        logic [59:0] px2;
        logic [59:0] py2;
    } t_prod;

    t_prod r_p, n_p;
    t_out  r_o, n_o;

    logic [OUT_STAGES-1:0] r_vld;
    logic [OUT_STAGES:0]   w_rdy;
    logic [OUT_STAGES-1:0] w_vin;

    assign w_rdy[OUT_STAGES] = i_ready;
    assign w_vin = {r_vld[OUT_STAGES-2:0], i_valid};

    for (genvar k = 0; k < OUT_STAGES; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    function automatic logic [36:0] round24(input logic [59:0] p);
        logic [60:0] r;
        r = 61'(p) + 61'd8388608;
        return r[60:24];
    endfunction

    always_comb begin
        n_p.first_id  = i_item.first_id;
        n_p.second_id = i_item.second_id;
        n_p.neg_x     = i_item.neg_x;
        n_p.neg_y     = i_item.neg_y;
        n_p.pos_x     = i_item.pos_x;
        n_p.pos_y     = i_item.pos_y;
        n_p.ovl       = i_item.ovl;
        n_p.dgn       = i_item.dgn;
        n_p.px1       = 60'(i_item.mag1) * 60'(i_item.ux);
        n_p.py1       = 60'(i_item.mag1) * 60'(i_item.uy);
        n_p.px2       = 60'(i_item.mag2) * 60'(i_item.ux);
        n_p.py2       = 60'(i_item.mag2) * 60'(i_item.uy);
    end

    always_comb begin
        logic apply;
        apply             = r_p.ovl && !r_p.dgn;
        n_o.out_first_id  = r_p.first_id;
        n_o.out_second_id = r_p.second_id;
        n_o.overlap       = r_p.ovl;
        n_o.degenerate    = r_p.dgn;
        n_o.first_move_x  = '0;
        n_o.first_move_y  = '0;
        n_o.second_move_x = '0;
        n_o.second_move_y = '0;
        if (apply) begin
            n_o.first_move_x  = sat_move(r_p.neg_x, round24(r_p.px1));
            n_o.first_move_y  = sat_move(r_p.neg_y, round24(r_p.py1));
            n_o.second_move_x = sat_move(r_p.pos_x, round24(r_p.px2));
            n_o.second_move_y = sat_move(r_p.pos_y, round24(r_p.py2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < OUT_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_p <= n_p;
        end
        if (w_rdy[1]) begin
            r_o <= n_o;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[OUT_STAGES-1];
    assign o_item  = r_o;

endmodule

### design/circle_pair_collision_response_unit.sv
// Circle pair collision response: takes one particle pair per clock while the input is ready
// and returns one result per pair, in order. The pipeline runs through front end, square root,
// direction divide and push scaling, and output stages; the square root resolves two result bits
// per stage and the direction dividers that follow it give two quotient bits per stage. Every
// stage holds its own valid bit and loads whenever the stage after it is empty or moving, so
// a stalled output lets bubbles close up and the input keeps taking requests until the whole
// pipeline is full. The damping register (Q1.16, reset 0.75) sits at APB address 0 and is
// meant to be written only while no request is in flight.
module circle_pair_collision_response_unit import cpcr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [16:0] r_damping;

    logic w_fr_valid, w_fr_ready;
    t_geo w_fr_item;
    logic w_rt_valid, w_rt_ready;
    t_geo w_rt_item;
    logic w_un_valid, w_un_ready;
    t_mag w_un_item;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping <= DAMPING_RST;
        end else if (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_DAMPING)) begin
            r_damping <= pwdata[16:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_DAMPING) begin
            prdata = 32'(r_damping);
        end
    end

    cpcr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .o_valid (w_fr_valid),
        .i_ready (w_fr_ready),
        .o_item  (w_fr_item)
    );

    cpcr_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_item  (w_fr_item),
        .o_valid (w_rt_valid),
        .i_ready (w_rt_ready),
        .o_item  (w_rt_item)
    );

    cpcr_unit u_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_damping (r_damping),
        .i_valid   (w_rt_valid),
        .o_ready   (w_rt_ready),
        .i_item    (w_rt_item),
        .o_valid   (w_un_valid),
        .i_ready   (w_un_ready),
        .o_item    (w_un_item)
    );

    cpcr_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_un_valid),
        .o_ready (w_un_ready),
        .i_item  (w_un_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

endmodule

### design/cpcr_checker.sv
// port-level checks for the circle pair collision response unit, bound to the top level
module cpcr_checker import cpcr_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.first_move_x == '0 && o_out_data.first_move_y == '0 &&
            o_out_data.second_move_x == '0 && o_out_data.second_move_y == '0)
        else $error("coincident centres gave a nonzero move");

    a_no_overlap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.overlap |->
            o_out_data.first_move_x == '0 && o_out_data.first_move_y == '0 &&
            o_out_data.second_move_x == '0 && o_out_data.second_move_y == '0)
        else $error("separated pair gave a nonzero move");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind circle_pair_collision_response_unit cpcr_checker u_cpcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
